/* rtl/elms_pkg.sv */
// ----------------------------------------------------------------------------
// ESR/LC measurement sequencer package
// Shared widths, register and generator codes, state types and helpers.
// ----------------------------------------------------------------------------
package elms_pkg;

  localparam int unsigned SlotDivideDef = 3;
  localparam int unsigned FracBits      = 16;
  localparam int unsigned AdcW          = 14;
  localparam int unsigned ResW          = 24;
  localparam int unsigned OpW           = 64;
  localparam int unsigned CfgAddrW      = 6;
  localparam int unsigned CfgDataW      = 64;

  localparam logic [AdcW-1:0] OverLevel = 14'd9800;
  localparam logic [OpW-1:0]  SatCapU   = 64'h4000_0000_0000_0000;
  localparam logic            ModeInd   = 1'b1;

  typedef enum logic [2:0] {
    REG_METER_MODE = 3'd0,
    REG_CAP_ZERO   = 3'd1,
    REG_CAP_TRIMS  = 3'd2,
    REG_IND_ZERO   = 3'd3,
    REG_IND_CORR   = 3'd4,
    REG_DCR_OFFSET = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    GEN_DUAL_72K = 3'd0,
    GEN_DUAL_3K  = 3'd1,
    GEN_72K_36K  = 3'd2,
    GEN_72K_0HZ  = 3'd3,
    GEN_DC       = 3'd4
  } gen_mode_e;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_CHK,
    MD_DIV,
    MD_DONE
  } md_state_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_ISSUE,
    SQ_WAIT,
    SQ_DONE
  } seq_state_e;

  typedef enum logic [4:0] {
    ST_VPP,
    ST_W_DIV,
    ST_W_SQ,
    ST_W_K,
    ST_W_FIN,
    ST_CAP,
    ST_COEF,
    ST_V,
    ST_ESR_PRE,
    ST_ESR,
    ST_CAP2,
    ST_R,
    ST_IND_E,
    ST_VY,
    ST_VZ,
    ST_PRI_PRE,
    ST_PRI,
    ST_SEC_PRE,
    ST_SEC
  } step_e;

  typedef struct packed {
    logic        meter_mode;
    logic [63:0] cap_zero_offsets;
    logic [31:0] cap_trims;
    logic [47:0] ind_zero_offsets;
    logic [31:0] ind_reactance_corr;
    logic [15:0] dcr_offset;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic signed [OpW-1:0] a;
    logic signed [OpW-1:0] b;
    logic signed [OpW-1:0] c;
  } md_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [OpW-1:0] res;
  } md_rsp_t;

  function automatic logic signed [OpW-1:0] sx16_f(logic [15:0] v);
    return {{(OpW-16){v[15]}}, v};
  endfunction

  function automatic logic signed [OpW-1:0] sx8_f(logic [7:0] v);
    return {{(OpW-8){v[7]}}, v};
  endfunction

  function automatic logic signed [ResW-1:0] sat24_f(logic signed [OpW-1:0] v);
    if (v > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[ResW-1:0];
  endfunction

  function automatic gen_mode_e gen_mode_f(logic ind, logic [1:0] ph);
    gen_mode_e m;
    case (ph)
      2'd0:    m = ind ? GEN_DC : GEN_DUAL_72K;
      2'd1:    m = GEN_DUAL_72K;
      2'd2:    m = GEN_DUAL_3K;
      default: m = ind ? GEN_72K_0HZ : GEN_72K_36K;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] gen_phase_f(logic ind, logic [1:0] ph);
    if (ph == 2'd1 || ph == 2'd2) begin
      return ind ? 8'd64 : 8'd192;
    end
    return 8'd0;
  endfunction

endpackage

/* rtl/esr_lc_measurement_sequencer.sv */
// ----------------------------------------------------------------------------
// ESR/LC measurement sequencer
// Slot counting, reading latches and the measurement sequence around one
// shared multiply-divide unit.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o | adc_reading_i, supply_reading_i
//  out     | output    | out_valid_o/out_ready_i | gen_*, meas_valid_o, values, flags
//  config  | input     | psel/penable/pwrite     | paddr, pwdata, prdata (64 bit)
//
//  A tick that falls between acting slots gives no result.
//  An acting tick runs a number of operations on the multiply-divide unit, each
//  made of issue, 64 multiply steps, a range check, 64 divide steps and done;
//  the check ends early on overflow, and an operand or divisor of zero goes to done:
//  one for the phase-0 supply level, 8 for an inductor result, 9 or 14 for a capacitor result.
//  The output register holds a result until taken; a new request is accepted
//  meanwhile, and a finished result waits in the done state until the slot frees.
//  Reset (rst_ni, asynchronous) clears the slot counter, the latched readings, the
//  control state, out_valid and the configuration, and loads the default signal level.
//
module esr_lc_measurement_sequencer import elms_pkg::*; #(
  parameter int unsigned SLOT_DIVIDE = SlotDivideDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrW-1:0]    paddr,
  input  logic [CfgDataW-1:0]    pwdata,
  output logic [CfgDataW-1:0]    prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [AdcW-1:0]        adc_reading_i,
  input  logic [AdcW-1:0]        supply_reading_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   gen_update_o,
  output logic [2:0]             gen_mode_o,
  output logic [7:0]             gen_phase_o,
  output logic                   meas_valid_o,
  output logic signed [ResW-1:0] primary_value_o,
  output logic signed [ResW-1:0] secondary_value_o,
  output logic signed [ResW-1:0] lowfreq_cap_o,
  output logic                   over_primary_o,
  output logic                   over_secondary_o
);

  localparam int unsigned SubW = (SLOT_DIVIDE > 1) ? $clog2(SLOT_DIVIDE) : 1;
  localparam logic [SubW-1:0] SubLast = SubW'(SLOT_DIVIDE - 1);

  localparam logic signed [OpW-1:0] OneQ  = 64'sd1 << FracBits;
  localparam logic signed [OpW-1:0] OneQ2 = 64'sd1 << (2 * FracBits);
  localparam logic signed [OpW-1:0] ELim  = 64'sd8 << FracBits;
  localparam logic [OpW-1:0]        VppRaw   = 64'd52500 << FracBits;
  localparam logic [31:0]           VppReset = (VppRaw > 64'h0000_0000_FFFF_FFFF) ?
                                               32'hFFFF_FFFF : VppRaw[31:0];

  // configuration
  cfg_t cfg;

  elms_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // shared unit
  md_req_t md_req;
  md_rsp_t md_rsp;

  elms_muldiv u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // sequencer state
  seq_state_e      state_q, state_d;
  step_e           step_q, step_d;
  logic            zpass_q, zpass_d;
  logic [SubW-1:0] sub_q;
  logic [2:0]      phase_q, act_phase_q, phase_new;
  logic [AdcW-1:0] dc_q, x_q, y_q, z_q, sup_q;
  logic [31:0]     vpp_q;

  // intermediates
  logic signed [OpW-1:0] e_q, e2_q, k_q, ew_q, coef_q, v_q, t_q;
  logic signed [OpW-1:0] ie_q, vyc_q, vzc_q, pri_q, sec_q, low_q;
  logic [15:0]           r_q;

  // output register
  logic                   out_valid_q;
  logic                   gen_update_q, meas_valid_q, over_p_q, over_s_q;
  logic [2:0]             gen_mode_q;
  logic [7:0]             gen_phase_q;
  logic signed [ResW-1:0] pri_out_q, sec_out_q, low_out_q;

  logic in_acc, act_now, ind_mode, meas_new, meas_cur, load_ok;

  assign ind_mode   = (cfg.meter_mode == ModeInd);
  assign in_ready_o = (state_q == SQ_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign act_now    = (sub_q == SubLast);
  assign phase_new  = phase_q + 3'd1;
  assign meas_new   = ind_mode ? phase_new[2] : (phase_new >= 3'd3);
  assign meas_cur   = ind_mode ? act_phase_q[2] : (act_phase_q >= 3'd3);
  assign load_ok    = !out_valid_q || out_ready_i;

  // ---- operand formation ----
  logic signed [OpW-1:0] dc_s, x_s, y_s, z_s;
  logic signed [OpW-1:0] vd, vx, vy, vz, lvl, j0, j1, cm;
  logic signed [OpW-1:0] ivd, ivy, ivz, rraw, rclamp, r_s;
  logic signed [32:0]    ar, br;
  logic [10:0]           gain;
  logic [20:0]           vpp_mul;

  assign dc_s = {{(OpW-AdcW){1'b0}}, dc_q};
  assign x_s  = {{(OpW-AdcW){1'b0}}, x_q};
  assign y_s  = {{(OpW-AdcW){1'b0}}, y_q};
  assign z_s  = {{(OpW-AdcW){1'b0}}, z_q};

  assign j0  = sx8_f(cfg.cap_trims[15:8]);
  assign j1  = sx8_f(cfg.cap_trims[23:16]);
  assign cm  = sx8_f(cfg.cap_trims[31:24]);
  assign vd  = dc_s - sx16_f(cfg.cap_zero_offsets[15:0]);
  assign vx  = x_s - sx16_f(cfg.cap_zero_offsets[31:16]) - vd;
  assign vy  = y_s - sx16_f(cfg.cap_zero_offsets[47:32]) - vd;
  assign vz  = z_s - sx16_f(cfg.cap_zero_offsets[63:48]) - vd + cm;
  assign lvl = zpass_q ? vz : vy;

  assign ivd    = dc_s - sx16_f(cfg.ind_zero_offsets[15:0]);
  assign ivy    = y_s - sx16_f(cfg.ind_zero_offsets[31:16]) - ivd;
  assign ivz    = z_s - sx16_f(cfg.ind_zero_offsets[47:32]) - ivd;
  assign rraw   = x_s + sx16_f(cfg.dcr_offset);
  assign rclamp = rraw[OpW-1] ? '0 : rraw;
  assign r_s    = {{(OpW-16){1'b0}}, r_q};
  assign ar     = $signed(cfg.ind_reactance_corr[15:0]) * $signed({1'b0, r_q});
  assign br     = $signed(cfg.ind_reactance_corr[31:16]) * $signed({1'b0, r_q});

  assign gain    = 11'(11'sd1000 + $signed(cfg.cap_trims[7:0]));
  assign vpp_mul = 21'(gain) * 21'd805;

  always_comb begin
    md_req.start = (state_q == SQ_ISSUE);
    md_req.a     = '0;
    md_req.b     = '0;
    md_req.c     = 64'sd1;
    case (step_q)
      ST_VPP: begin
        md_req.a = {{(OpW-AdcW){1'b0}}, sup_q};
        md_req.b = {{(OpW-21){1'b0}}, vpp_mul} << FracBits;
        md_req.c = 64'sd100000;
      end
      ST_W_DIV: begin
        md_req.a = lvl;
        md_req.b = OneQ2;
        md_req.c = {32'd0, vpp_q};
      end
      ST_W_SQ: begin
        md_req.a = e_q;
        md_req.b = e_q;
        md_req.c = OneQ;
      end
      ST_W_K: begin
        md_req.a = e2_q;
        md_req.b = 64'sd17;
        md_req.c = 64'sd10;
      end
      ST_W_FIN: begin
        md_req.a = e_q;
        md_req.b = k_q;
        md_req.c = OneQ;
      end
      ST_CAP: begin
        md_req.a = 64'sd14050;
        md_req.b = OneQ;
        md_req.c = ew_q * 64'sd832;
      end
      ST_COEF: begin
        md_req.a = 64'sd1333 + 64'sd5 * j1;
        md_req.b = ew_q;
      end
      ST_V: begin
        md_req.a = vy;
        md_req.b = coef_q;
        md_req.c = 64'sd1000 << FracBits;
      end
      ST_ESR_PRE: begin
        md_req.a = vx - v_q;
        md_req.b = 64'sd10400;
      end
      ST_ESR: begin
        md_req.a = t_q;
        md_req.b = OneQ;
        md_req.c = $signed({32'd0, vpp_q}) - (vx <<< FracBits);
      end
      ST_CAP2: begin
        md_req.a = 64'sd337200;
        md_req.b = OneQ;
        md_req.c = ew_q * 64'sd832;
      end
      ST_R: begin
        md_req.a = rclamp;
        md_req.b = 64'sd2;
        md_req.c = 64'sd3;
      end
      ST_IND_E: begin
        md_req.a = 64'sd354;
        md_req.b = OneQ2;
        md_req.c = {32'd0, vpp_q};
      end
      ST_VY: begin
        md_req.a = ivy * 64'sd2000 - {{(OpW-33){ar[32]}}, ar};
        md_req.b = 64'sd1;
        md_req.c = 64'sd2000;
      end
      ST_VZ: begin
        md_req.a = ivz * 64'sd2000 - {{(OpW-33){br[32]}}, br};
        md_req.b = 64'sd1;
        md_req.c = 64'sd2000;
      end
      ST_PRI_PRE: begin
        md_req.a = vyc_q;
        md_req.b = (64'sd5000 + r_s) * 64'sd100;
      end
      ST_PRI: begin
        md_req.a = ie_q;
        md_req.b = t_q;
        md_req.c = 64'sd5000 << FracBits;
      end
      ST_SEC_PRE: begin
        md_req.a = vzc_q;
        md_req.b = (64'sd50000 + 64'sd7 * r_s) * 64'sd2430;
      end
      ST_SEC: begin
        md_req.a = ie_q;
        md_req.b = t_q;
        md_req.c = 64'sd50000 << FracBits;
      end
      default: ;
    endcase
  end

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    zpass_d = zpass_q;
    case (state_q)
      SQ_IDLE: begin
        if (in_acc && act_now) begin
          if (phase_new == 3'd0) begin
            step_d  = ST_VPP;
            state_d = SQ_ISSUE;
          end else if (meas_new) begin
            step_d  = ind_mode ? ST_R : ST_W_DIV;
            zpass_d = 1'b0;
            state_d = SQ_ISSUE;
          end else begin
            state_d = SQ_DONE;
          end
        end
      end
      SQ_ISSUE: state_d = SQ_WAIT;
      SQ_WAIT: begin
        if (md_rsp.done) begin
          state_d = SQ_ISSUE;
          case (step_q)
            ST_VPP:     state_d = SQ_DONE;
            ST_W_DIV:   step_d = ST_W_SQ;
            ST_W_SQ:    step_d = ST_W_K;
            ST_W_K:     step_d = ST_W_FIN;
            ST_W_FIN:   step_d = zpass_q ? ST_CAP2 : ST_CAP;
            ST_CAP:     step_d = ST_COEF;
            ST_COEF:    step_d = ST_V;
            ST_V:       step_d = ST_ESR_PRE;
            ST_ESR_PRE: step_d = ST_ESR;
            ST_ESR: begin
              // skip the low-frequency pass when the Z reading is over range
              if (z_q < OverLevel) begin
                step_d  = ST_W_DIV;
                zpass_d = 1'b1;
              end else begin
                state_d = SQ_DONE;
              end
            end
            ST_CAP2:    state_d = SQ_DONE;
            ST_R:       step_d = ST_IND_E;
            ST_IND_E:   step_d = ST_VY;
            ST_VY:      step_d = ST_VZ;
            ST_VZ:      step_d = ST_PRI_PRE;
            ST_PRI_PRE: step_d = ST_PRI;
            ST_PRI:     step_d = ST_SEC_PRE;
            ST_SEC_PRE: step_d = ST_SEC;
            ST_SEC:     state_d = SQ_DONE;
            default:    state_d = SQ_DONE;
          endcase
        end
      end
      SQ_DONE: if (load_ok) state_d = SQ_IDLE;
      default: state_d = SQ_IDLE;
    endcase
  end

  // ---- control and latched state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      step_q      <= ST_VPP;
      zpass_q     <= 1'b0;
      sub_q       <= '0;
      phase_q     <= '0;
      act_phase_q <= '0;
      dc_q        <= '0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      vpp_q       <= VppReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      zpass_q <= zpass_d;
      if (in_acc) begin
        sub_q <= act_now ? '0 : sub_q + 1'b1;
        if (act_now) begin
          phase_q     <= phase_new;
          act_phase_q <= phase_new;
          // latch the reading of this phase
          if (!phase_new[2]) begin
            case (phase_new[1:0])
              2'd0:    dc_q <= adc_reading_i;
              2'd1:    x_q  <= adc_reading_i;
              2'd2:    y_q  <= adc_reading_i;
              default: z_q  <= adc_reading_i;
            endcase
          end
        end
      end
      if (state_q == SQ_WAIT && md_rsp.done && step_q == ST_VPP) begin
        vpp_q <= (md_rsp.res > 64'sh0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF :
                                                           md_rsp.res[31:0];
      end
      if (state_q == SQ_DONE && load_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- intermediate results ----
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sup_q <= supply_reading_i;
    end
    if (state_q == SQ_WAIT && md_rsp.done) begin
      case (step_q)
        ST_W_DIV: begin
          if (md_rsp.res > ELim) begin
            e_q <= ELim;
          end else if (md_rsp.res < -ELim) begin
            e_q <= -ELim;
          end else begin
            e_q <= md_rsp.res;
          end
        end
        ST_W_SQ:    e2_q   <= md_rsp.res;
        ST_W_K:     k_q    <= OneQ + md_rsp.res;
        ST_W_FIN:   ew_q   <= md_rsp.res;
        ST_CAP:     sec_q  <= md_rsp.res;
        ST_COEF:    coef_q <= md_rsp.res - (j0 <<< FracBits);
        ST_V:       v_q    <= md_rsp.res;
        ST_ESR_PRE: t_q    <= md_rsp.res;
        ST_ESR: begin
          pri_q <= md_rsp.res;
          low_q <= '0;
        end
        ST_CAP2:    low_q  <= md_rsp.res;
        ST_R:       r_q    <= md_rsp.res[15:0];
        ST_IND_E:   ie_q   <= md_rsp.res;
        ST_VY:      vyc_q  <= md_rsp.res;
        ST_VZ:      vzc_q  <= md_rsp.res;
        ST_PRI_PRE: t_q    <= md_rsp.res;
        ST_PRI:     pri_q  <= md_rsp.res;
        ST_SEC_PRE: t_q    <= md_rsp.res;
        ST_SEC:     sec_q  <= md_rsp.res;
        default: ;
      endcase
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i) begin
    if (state_q == SQ_DONE && load_ok) begin
      gen_update_q <= !act_phase_q[2];
      gen_mode_q   <= act_phase_q[2] ? '0 : gen_mode_f(ind_mode, act_phase_q[1:0]);
      gen_phase_q  <= act_phase_q[2] ? '0 : gen_phase_f(ind_mode, act_phase_q[1:0]);
      meas_valid_q <= meas_cur;
      pri_out_q    <= meas_cur ? sat24_f(pri_q) : '0;
      sec_out_q    <= meas_cur ? sat24_f(sec_q) : '0;
      low_out_q    <= (meas_cur && !ind_mode) ? sat24_f(low_q) : '0;
      over_p_q     <= meas_cur && (ind_mode ? (y_q > OverLevel) :
                                   (x_q > OverLevel || y_q > OverLevel));
      over_s_q     <= meas_cur && (ind_mode ? (z_q > OverLevel) : (z_q >= OverLevel));
    end
  end

  assign out_valid_o       = out_valid_q;
  assign gen_update_o      = gen_update_q;
  assign gen_mode_o        = gen_mode_q;
  assign gen_phase_o       = gen_phase_q;
  assign meas_valid_o      = meas_valid_q;
  assign primary_value_o   = pri_out_q;
  assign secondary_value_o = sec_out_q;
  assign lowfreq_cap_o     = low_out_q;
  assign over_primary_o    = over_p_q;
  assign over_secondary_o  = over_s_q;

endmodule

/* rtl/elms_regs.sv */
// ----------------------------------------------------------------------------
// ESR/LC configuration registers
// APB-style register file, zero wait states, 64-bit data.
// ----------------------------------------------------------------------------
module elms_regs import elms_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_METER_MODE: cfg_q.meter_mode         <= pwdata[0];
        REG_CAP_ZERO:   cfg_q.cap_zero_offsets   <= pwdata;
        REG_CAP_TRIMS:  cfg_q.cap_trims          <= pwdata[31:0];
        REG_IND_ZERO:   cfg_q.ind_zero_offsets   <= pwdata[47:0];
        REG_IND_CORR:   cfg_q.ind_reactance_corr <= pwdata[31:0];
        REG_DCR_OFFSET: cfg_q.dcr_offset         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_METER_MODE: prdata = {63'd0, cfg_q.meter_mode};
      REG_CAP_ZERO:   prdata = cfg_q.cap_zero_offsets;
      REG_CAP_TRIMS:  prdata = {32'd0, cfg_q.cap_trims};
      REG_IND_ZERO:   prdata = {16'd0, cfg_q.ind_zero_offsets};
      REG_IND_CORR:   prdata = {32'd0, cfg_q.ind_reactance_corr};
      REG_DCR_OFFSET: prdata = {48'd0, cfg_q.dcr_offset};
      default:        prdata = '0;
    endcase
  end

endmodule

/* rtl/elms_muldiv.sv */
// ----------------------------------------------------------------------------
// ESR/LC shared multiply-divide unit
// Signed trunc(a*b/c): bit-serial multiply to 128 bits, then restoring divide.
// ----------------------------------------------------------------------------
module elms_muldiv import elms_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(OpW);

  md_state_e      state_q, state_d;
  logic [OpW-1:0] ua, ub, uc;
  logic           neg_in, zero_in, czero_in;
  logic [OpW-1:0] mcand_q, mplier_q, dvsr_q, hi_q, lo_q;
  logic           neg_q;
  logic [CntW-1:0] cnt_q;
  logic [OpW:0]   mul_sum, rem_x, rem_sub;
  logic           rem_ge;
  logic [OpW-1:0] mag;

  assign ua = req_i.a[OpW-1] ? (~$unsigned(req_i.a) + 1'b1) : $unsigned(req_i.a);
  assign ub = req_i.b[OpW-1] ? (~$unsigned(req_i.b) + 1'b1) : $unsigned(req_i.b);
  assign uc = req_i.c[OpW-1] ? (~$unsigned(req_i.c) + 1'b1) : $unsigned(req_i.c);

  assign zero_in  = (ua == '0) || (ub == '0);
  assign czero_in = (uc == '0);
  // a negative divisor is never zero, so its sign bit flips the result
  assign neg_in   = req_i.a[OpW-1] ^ req_i.b[OpW-1] ^ req_i.c[OpW-1];

  assign mul_sum = {1'b0, hi_q} + (mplier_q[0] ? {1'b0, mcand_q} : '0);
  assign rem_x   = {hi_q, lo_q[OpW-1]};
  assign rem_ge  = rem_x >= {1'b0, dvsr_q};
  assign rem_sub = rem_x - {1'b0, dvsr_q};
  assign mag     = (lo_q > SatCapU) ? SatCapU : lo_q;

  assign rsp_o.done = (state_q == MD_DONE);
  assign rsp_o.res  = neg_q ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == MD_IDLE) begin
        cnt_q <= '0;
      end else if (state_q == MD_MUL || state_q == MD_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          mcand_q  <= ua;
          mplier_q <= ub;
          dvsr_q   <= uc;
          neg_q    <= neg_in;
          hi_q     <= '0;
          lo_q     <= zero_in ? '0 : (czero_in ? SatCapU : '0);
        end
      end
      MD_MUL: begin
        hi_q     <= mul_sum[OpW:1];
        lo_q     <= {mul_sum[0], lo_q[OpW-1:1]};
        mplier_q <= mplier_q >> 1;
      end
      MD_CHK: begin
        if (hi_q >= dvsr_q) begin
          lo_q <= SatCapU;
        end
      end
      MD_DIV: begin
        hi_q <= rem_ge ? rem_sub[OpW-1:0] : rem_x[OpW-1:0];
        lo_q <= {lo_q[OpW-2:0], rem_ge};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          state_d = (zero_in || czero_in) ? MD_DONE : MD_MUL;
        end
      end
      MD_MUL:  if (&cnt_q) state_d = MD_CHK;
      MD_CHK:  state_d = (hi_q >= dvsr_q) ? MD_DONE : MD_DIV;
      MD_DIV:  if (&cnt_q) state_d = MD_DONE;
      MD_DONE: state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

endmodule

/* rtl/elms_checker.sv */
// ----------------------------------------------------------------------------
// ESR/LC sequencer port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module elms_checker import elms_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   pready,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic                   gen_update_o,
  input logic [2:0]             gen_mode_o,
  input logic [7:0]             gen_phase_o,
  input logic                   meas_valid_o,
  input logic signed [ResW-1:0] primary_value_o,
  input logic signed [ResW-1:0] secondary_value_o,
  input logic signed [ResW-1:0] lowfreq_cap_o,
  input logic                   over_primary_o,
  input logic                   over_secondary_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(primary_value_o))
    else $error("result dropped while stalled");

  // every result carries a generator setting or a measurement
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gen_update_o || meas_valid_o) && pready)
    else $error("empty result");

  a_gen_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !gen_update_o |-> gen_mode_o == '0 && gen_phase_o == '0)
    else $error("generator fields not blank");

  a_meas_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !meas_valid_o |-> primary_value_o == '0 && secondary_value_o == '0
      && lowfreq_cap_o == '0 && !over_primary_o && !over_secondary_o)
    else $error("measurement fields not blank");

  // only the capacitor Z phase issues a setting and a measurement together
  a_joint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gen_update_o && meas_valid_o |-> gen_mode_o == GEN_72K_36K)
    else $error("unexpected joint result");

endmodule

bind esr_lc_measurement_sequencer elms_checker u_elms_checker (.*);
